FILE: design/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg
// Shared constants, microcode word layout and handshake structs for the
// anti-aliased circle rasteriser.
// ----------------------------------------------------------------------------
package acr_pkg;

  // sub-pixel and coordinate geometry
  localparam int AA_FRAC_BITS = 3;
  localparam int COORD_BITS   = 12;
  localparam int RAD_W        = 26;                             // 10.16 radius
  localparam int RAD_FRAC     = 16;
  localparam int CTR_W        = COORD_BITS + 1;                 // latched centre
  localparam int PIX_W        = COORD_BITS + 1;                 // plotted pixel
  localparam int SUB_W        = RAD_W - RAD_FRAC + AA_FRAC_BITS + 1;
  localparam int ERR_W        = 24;
  localparam int INT_W        = 3;

  localparam int AA_ONE   = 1 << AA_FRAC_BITS;
  localparam int AA_MASK  = AA_ONE - 1;
  localparam int ERR_BIAS = AA_ONE + (1 << (AA_FRAC_BITS + 2)) - 2;

  // configuration port
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int CFG_W   = COORD_BITS;
  localparam logic REG_X_OFFSET = 1'b0;
  localparam logic REG_Y_OFFSET = 1'b1;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // microprogram
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_WAIT   = PC_W'(0);
  localparam logic [PC_W-1:0] PC_ERRADD = PC_W'(1);
  localparam logic [PC_W-1:0] PC_REDUCE = PC_W'(2);
  localparam logic [PC_W-1:0] PC_FLAG   = PC_W'(3);
  localparam logic [PC_W-1:0] PC_PLOT0  = PC_W'(4);
  localparam logic [PC_W-1:0] PC_COMMIT = PC_W'(20);

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_ERRADD,
    OP_REDUCE,
    OP_FLAG,
    OP_PLOT,
    OP_COMMIT
  } op_e;

  // offset added to a centre coordinate
  typedef enum logic [1:0] {
    SEL_POS_X,
    SEL_NEG_X,
    SEL_POS_Y,
    SEL_NEG_Y
  } sel_e;

  typedef enum logic [1:0] {
    ADJ_NONE,
    ADJ_INC,
    ADJ_DEC
  } adj_e;

  typedef struct packed {
    op_e             op;
    sel_e            xsel;
    adj_e            xadj;
    sel_e            ysel;
    adj_e            yadj;
    logic            use_fr;
    logic            last;
    logic [PC_W-1:0] target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    uword_t w;
    logic   fire;
  } cmd_t;

  // datapath to sequencer
  typedef struct packed {
    logic active;
    logic reduce_more;
    logic out_free;
  } stat_t;

endpackage

FILE: design/antialiased_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// antialiased_circle_rasterizer
// Anti-aliased midpoint circle rasteriser, microcoded control over a small
// datapath.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o    req_type, center_x/y, radius
//   out      source     out_valid_o / out_stall_i  pixel_x/y, intensity, last,
//                                                  finished
//   cfg      APB        psel/penable/pready        x_offset, y_offset
//
// A load request is accepted in the wait step and does not leave it. A step
// request on a live circle runs the error update, the x reductions of the
// inner loop, the finish flag, the plots and the commit before the next
// acceptance; the shared error adder (one subtract per cycle) and the single
// output register (one plot per cycle unless stalled) carry that work.
// Reset clears the step counter, the circle state and the output valid.
// A stalled output holds the program on its current plot.
// ----------------------------------------------------------------------------
module antialiased_circle_rasterizer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [acr_pkg::APB_AW-1:0]            paddr,
  input  logic [acr_pkg::APB_DW-1:0]            pwdata,
  output logic [acr_pkg::APB_DW-1:0]            prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  req_type_i,
  input  logic signed [acr_pkg::COORD_BITS-1:0] center_x_i,
  input  logic signed [acr_pkg::COORD_BITS-1:0] center_y_i,
  input  logic [acr_pkg::RAD_W-1:0]             radius_fixed_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [acr_pkg::PIX_W-1:0]      pixel_x_o,
  output logic signed [acr_pkg::PIX_W-1:0]      pixel_y_o,
  output logic [acr_pkg::INT_W-1:0]             intensity_o,
  output logic                                  last_o,
  output logic                                  finished_o
);
  import acr_pkg::*;

  logic signed [CFG_W-1:0] x_off, y_off;
  logic [PC_W-1:0]         pc;
  uword_t                  word;
  cmd_t                    cmd;
  stat_t                   stat;
  logic                    in_acc;

  acr_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .x_offset_o (x_off),
    .y_offset_o (y_off)
  );

  acr_ucode_rom u_rom (
    .pc_i   (pc),
    .word_o (word)
  );

  acr_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .word_i     (word),
    .stat_i     (stat),
    .pc_o       (pc),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  acr_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_type_i     (req_type_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .radius_fixed_i (radius_fixed_i),
    .x_offset_i     (x_off),
    .y_offset_i     (y_off),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .intensity_o    (intensity_o),
    .last_o         (last_o),
    .finished_o     (finished_o)
  );

  assign in_acc = in_valid_i && !in_stall_o;

  // a load always leaves a live circle
  a_load_sets_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (req_type_i == REQ_LOAD) |=> stat.active)
    else $error("load request did not set active");

  // a step on a live circle starts the program
  a_step_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (req_type_i == REQ_STEP) && stat.active |=> in_stall_o)
    else $error("step request did not start the program");

  // every issued plot lands in the output register
  a_plot_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fire && (cmd.w.op == OP_PLOT) |=> out_valid_o)
    else $error("issued plot missing from output register");

endmodule

FILE: design/acr_apb_regs.sv
// ----------------------------------------------------------------------------
// acr_apb_regs
// Configuration registers (screen offsets) behind an APB-style port.
// ----------------------------------------------------------------------------
module acr_apb_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [acr_pkg::APB_AW-1:0]       paddr,
  input  logic [acr_pkg::APB_DW-1:0]       pwdata,
  output logic [acr_pkg::APB_DW-1:0]       prdata,
  output logic                             pready,
  output logic signed [acr_pkg::CFG_W-1:0] x_offset_o,
  output logic signed [acr_pkg::CFG_W-1:0] y_offset_o
);
  import acr_pkg::*;

  logic signed [CFG_W-1:0] x_off_q, y_off_q;
  logic                    wr_en;
  logic                    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q <= '0;
      y_off_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_X_OFFSET: x_off_q <= pwdata[CFG_W-1:0];
        REG_Y_OFFSET: y_off_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_X_OFFSET: prdata = APB_DW'(unsigned'(x_off_q));
      REG_Y_OFFSET: prdata = APB_DW'(unsigned'(y_off_q));
      default: prdata = '0;
    endcase
  end

  assign x_offset_o = x_off_q;
  assign y_offset_o = y_off_q;

endmodule

FILE: design/acr_ucode_rom.sv
// ----------------------------------------------------------------------------
// acr_ucode_rom
// Read-only control store: one control word per step of the program.
// ----------------------------------------------------------------------------
module acr_ucode_rom (
  input  logic [acr_pkg::PC_W-1:0] pc_i,
  output acr_pkg::uword_t          word_o
);
  import acr_pkg::*;

  function automatic uword_t ctl(op_e op, logic [PC_W-1:0] target);
    uword_t w;
    w        = '0;
    w.op     = op;
    w.xadj   = ADJ_NONE;
    w.yadj   = ADJ_NONE;
    w.target = target;
    return w;
  endfunction

  function automatic uword_t plot(sel_e xs, adj_e xa, sel_e ys, adj_e ya,
                                  logic fr, logic last);
    uword_t w;
    w        = '0;
    w.op     = OP_PLOT;
    w.xsel   = xs;
    w.xadj   = xa;
    w.ysel   = ys;
    w.yadj   = ya;
    w.use_fr = fr;
    w.last   = last;
    w.target = PC_WAIT;
    return w;
  endfunction

  // program: wait, error update, x reduction loop, finish flag,
  // sixteen plots (wide octants then tall octants), commit
  always_comb begin
    unique case (pc_i)
      5'd0:  word_o = ctl(OP_WAIT,   PC_ERRADD);
      5'd1:  word_o = ctl(OP_ERRADD, PC_WAIT);
      5'd2:  word_o = ctl(OP_REDUCE, PC_WAIT);
      5'd3:  word_o = ctl(OP_FLAG,   PC_WAIT);
      // wide pixels
      5'd4:  word_o = plot(SEL_POS_X, ADJ_NONE, SEL_POS_Y, ADJ_NONE, 1'b0, 1'b0);
      5'd5:  word_o = plot(SEL_POS_X, ADJ_INC,  SEL_POS_Y, ADJ_NONE, 1'b1, 1'b0);
      5'd6:  word_o = plot(SEL_POS_X, ADJ_NONE, SEL_NEG_Y, ADJ_NONE, 1'b0, 1'b0);
      5'd7:  word_o = plot(SEL_POS_X, ADJ_INC,  SEL_NEG_Y, ADJ_NONE, 1'b1, 1'b0);
      5'd8:  word_o = plot(SEL_NEG_X, ADJ_NONE, SEL_NEG_Y, ADJ_NONE, 1'b0, 1'b0);
      5'd9:  word_o = plot(SEL_NEG_X, ADJ_DEC,  SEL_NEG_Y, ADJ_NONE, 1'b1, 1'b0);
      5'd10: word_o = plot(SEL_NEG_X, ADJ_NONE, SEL_POS_Y, ADJ_NONE, 1'b0, 1'b0);
      5'd11: word_o = plot(SEL_NEG_X, ADJ_DEC,  SEL_POS_Y, ADJ_NONE, 1'b1, 1'b0);
      // tall pixels
      5'd12: word_o = plot(SEL_POS_Y, ADJ_NONE, SEL_POS_X, ADJ_NONE, 1'b0, 1'b0);
      5'd13: word_o = plot(SEL_POS_Y, ADJ_NONE, SEL_POS_X, ADJ_INC,  1'b1, 1'b0);
      5'd14: word_o = plot(SEL_POS_Y, ADJ_NONE, SEL_NEG_X, ADJ_NONE, 1'b0, 1'b0);
      5'd15: word_o = plot(SEL_POS_Y, ADJ_NONE, SEL_NEG_X, ADJ_DEC,  1'b1, 1'b0);
      5'd16: word_o = plot(SEL_NEG_Y, ADJ_NONE, SEL_NEG_X, ADJ_NONE, 1'b0, 1'b0);
      5'd17: word_o = plot(SEL_NEG_Y, ADJ_NONE, SEL_NEG_X, ADJ_DEC,  1'b1, 1'b0);
      5'd18: word_o = plot(SEL_NEG_Y, ADJ_NONE, SEL_POS_X, ADJ_NONE, 1'b0, 1'b0);
      5'd19: word_o = plot(SEL_NEG_Y, ADJ_NONE, SEL_POS_X, ADJ_INC,  1'b1, 1'b1);
      5'd20: word_o = ctl(OP_COMMIT, PC_WAIT);
      default: word_o = ctl(OP_WAIT, PC_ERRADD);
    endcase
  end

endmodule

FILE: design/acr_sequencer.sv
// ----------------------------------------------------------------------------
// acr_sequencer
// Step counter with conditional jumps; issues the current control word to
// the datapath and owns the input handshake.
// ----------------------------------------------------------------------------
module acr_sequencer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     req_type_i,
  input  acr_pkg::uword_t          word_i,
  input  acr_pkg::stat_t           stat_i,
  output logic [acr_pkg::PC_W-1:0] pc_o,
  output acr_pkg::cmd_t            cmd_o,
  output logic                     in_stall_o
);
  import acr_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  logic            fire;

  // next step and strobe
  always_comb begin
    pc_d = pc_q;
    fire = 1'b0;
    unique case (word_i.op) inside
      OP_WAIT: begin
        fire = in_valid_i;
        if (in_valid_i && (req_type_i == REQ_STEP) && stat_i.active) begin
          pc_d = word_i.target;
        end
      end
      OP_ERRADD, OP_FLAG: begin
        fire = 1'b1;
        pc_d = pc_q + PC_W'(1);
      end
      OP_REDUCE: begin
        fire = 1'b1;
        if (!stat_i.reduce_more) begin
          pc_d = pc_q + PC_W'(1);
        end
      end
      OP_PLOT: begin
        // hold while the output register is still full
        fire = stat_i.out_free;
        if (stat_i.out_free) begin
          pc_d = pc_q + PC_W'(1);
        end
      end
      OP_COMMIT: begin
        fire = 1'b1;
        pc_d = word_i.target;
      end
      default: pc_d = PC_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign pc_o       = pc_q;
  assign cmd_o.w    = word_i;
  assign cmd_o.fire = fire;
  assign in_stall_o = (word_i.op != OP_WAIT);

endmodule

FILE: design/acr_datapath.sv
// ----------------------------------------------------------------------------
// acr_datapath
// Circle state, midpoint error arithmetic, plot address generation and the
// output register.
// ----------------------------------------------------------------------------
module acr_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  acr_pkg::cmd_t                         cmd_i,
  output acr_pkg::stat_t                        stat_o,
  input  logic                                  req_type_i,
  input  logic signed [acr_pkg::COORD_BITS-1:0] center_x_i,
  input  logic signed [acr_pkg::COORD_BITS-1:0] center_y_i,
  input  logic [acr_pkg::RAD_W-1:0]             radius_fixed_i,
  input  logic signed [acr_pkg::CFG_W-1:0]      x_offset_i,
  input  logic signed [acr_pkg::CFG_W-1:0]      y_offset_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [acr_pkg::PIX_W-1:0]      pixel_x_o,
  output logic signed [acr_pkg::PIX_W-1:0]      pixel_y_o,
  output logic [acr_pkg::INT_W-1:0]             intensity_o,
  output logic                                  last_o,
  output logic                                  finished_o
);
  import acr_pkg::*;

  logic signed [CTR_W-1:0] center_x_q, center_y_q;
  logic signed [SUB_W-1:0] sub_x_q, wx_q;
  logic [SUB_W-1:0]        sub_y_q;
  logic signed [ERR_W-1:0] err_q;
  logic                    active_q, fin_q;

  logic                    out_valid_q;
  logic signed [PIX_W-1:0] pix_x_q, pix_y_q;
  logic [INT_W-1:0]        int_q;
  logic                    last_q, fin_out_q;

  logic                    out_free, reduce_more, is_load;
  logic [SUB_W-1:0]        rad_sub;
  logic signed [ERR_W-1:0] y_term, x_term, err_bias;
  logic signed [SUB_W:0]   y_next, wx_ext;
  logic signed [PIX_W-1:0] xi, yi, off_x, off_y, pix_x, pix_y;
  logic [AA_FRAC_BITS-1:0] fr, co;

  function automatic logic signed [PIX_W-1:0] pick(sel_e s,
      logic signed [PIX_W-1:0] a, logic signed [PIX_W-1:0] b);
    logic signed [PIX_W-1:0] r;
    case (s)
      SEL_POS_X: r = a;
      SEL_NEG_X: r = -a;
      SEL_POS_Y: r = b;
      SEL_NEG_Y: r = -b;
      default:   r = a;
    endcase
    return r;
  endfunction

  function automatic logic signed [PIX_W-1:0] adj(adj_e a);
    logic signed [PIX_W-1:0] r;
    case (a)
      ADJ_INC: r = PIX_W'(1);
      ADJ_DEC: r = -PIX_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // status towards the sequencer
  assign out_free    = !out_valid_q || !out_stall_i;
  assign reduce_more = !err_q[ERR_W-1] && !wx_q[SUB_W-1];
  assign stat_o      = '{active: active_q, reduce_more: reduce_more, out_free: out_free};

  assign is_load = cmd_i.fire && (cmd_i.w.op == OP_WAIT) && (req_type_i == REQ_LOAD);

  // error terms
  assign rad_sub  = SUB_W'(radius_fixed_i >> (RAD_FRAC - AA_FRAC_BITS));
  assign y_term   = signed'(ERR_W'({sub_y_q, (AA_FRAC_BITS + 1)'(0)}));
  assign x_term   = (ERR_W'(wx_q) <<< 1) + ERR_W'(2);
  assign err_bias = ERR_W'(ERR_BIAS);

  // finish test: next y against reduced x
  assign y_next = signed'({1'b0, sub_y_q} + (SUB_W + 1)'(AA_ONE));
  assign wx_ext = (SUB_W + 1)'(wx_q);

  // plot address and coverage
  assign xi    = PIX_W'(sub_x_q >>> AA_FRAC_BITS);
  assign yi    = signed'(PIX_W'(sub_y_q >> AA_FRAC_BITS));
  assign off_x = pick(cmd_i.w.xsel, xi, yi);
  assign off_y = pick(cmd_i.w.ysel, xi, yi);
  assign pix_x = PIX_W'(center_x_q) + off_x + adj(cmd_i.w.xadj);
  assign pix_y = PIX_W'(center_y_q) + off_y + adj(cmd_i.w.yadj);
  assign fr    = sub_x_q[AA_FRAC_BITS-1:0];
  assign co    = AA_FRAC_BITS'(AA_MASK) - fr;

  // circle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      sub_x_q    <= '0;
      sub_y_q    <= '0;
      wx_q       <= '0;
      err_q      <= '0;
      active_q   <= 1'b0;
      fin_q      <= 1'b0;
    end else if (cmd_i.fire) begin
      case (cmd_i.w.op)
        OP_WAIT: begin
          if (is_load) begin
            center_x_q <= CTR_W'(center_x_i) + CTR_W'(x_offset_i);
            center_y_q <= CTR_W'(center_y_i) + CTR_W'(y_offset_i);
            sub_x_q    <= signed'(rad_sub);
            sub_y_q    <= '0;
            err_q      <= -signed'(ERR_W'(rad_sub));
            active_q   <= 1'b1;
          end
        end
        OP_ERRADD: begin
          err_q <= err_q + y_term + err_bias;
          wx_q  <= sub_x_q;
        end
        OP_REDUCE: begin
          if (reduce_more) begin
            err_q <= err_q - x_term;
            wx_q  <= wx_q - SUB_W'(1);
          end
        end
        OP_FLAG: fin_q <= (y_next > wx_ext);
        OP_COMMIT: begin
          sub_x_q  <= wx_q;
          sub_y_q  <= sub_y_q + SUB_W'(AA_ONE);
          active_q <= !fin_q;
        end
        default: ;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fire && (cmd_i.w.op == OP_PLOT)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.fire && (cmd_i.w.op == OP_PLOT)) begin
      pix_x_q   <= pix_x;
      pix_y_q   <= pix_y;
      int_q     <= INT_W'(cmd_i.w.use_fr ? fr : co);
      last_q    <= cmd_i.w.last;
      fin_out_q <= fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = pix_x_q;
  assign pixel_y_o   = pix_y_q;
  assign intensity_o = int_q;
  assign last_o      = last_q;
  assign finished_o  = fin_out_q;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the anti-aliased circle rasteriser. A queue of
// load and step requests feeds a clocked driver; every accepted request is
// run through a cycle-free model of the midpoint circle, and the expected
// plots are compared in order against the output channel. Both channels see
// random idle gaps, and the screen offsets are rewritten between phases.
// ----------------------------------------------------------------------------
module tb;

  import acr_pkg::*;

  localparam longint unsigned RUN_LIMIT_NS = 40_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam logic [APB_AW-1:0] ADDR_X_OFFSET = {REG_X_OFFSET, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_Y_OFFSET = {REG_Y_OFFSET, 2'b00};
  localparam int SUB_SHIFT = RAD_FRAC - AA_FRAC_BITS;

  typedef struct packed {
    logic                         kind;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [RAD_W-1:0]             rad;
  } circ_req_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
    logic [INT_W-1:0]        inten;
    logic                    is_last;
    logic                    is_fin;
  } plot_t;

  // DUT connections
  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         psel           = 1'b0;
  logic                         penable        = 1'b0;
  logic                         pwrite         = 1'b0;
  logic [APB_AW-1:0]            paddr          = '0;
  logic [APB_DW-1:0]            pwdata         = '0;
  logic [APB_DW-1:0]            prdata;
  logic                         pready;
  logic                         in_valid_i     = 1'b0;
  logic                         in_stall_o;
  logic                         req_type_i     = REQ_LOAD;
  logic signed [COORD_BITS-1:0] center_x_i     = '0;
  logic signed [COORD_BITS-1:0] center_y_i     = '0;
  logic [RAD_W-1:0]             radius_fixed_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i    = 1'b0;
  logic signed [PIX_W-1:0]      pixel_x_o;
  logic signed [PIX_W-1:0]      pixel_y_o;
  logic [INT_W-1:0]             intensity_o;
  logic                         last_o;
  logic                         finished_o;

  // circle model state
  longint off_x = 0;
  longint off_y = 0;
  longint ctr_x = 0;
  longint ctr_y = 0;
  longint sub_px = 0;
  longint sub_py = 0;
  longint acc_err = 0;
  bit     circle_live = 1'b0;

  circ_req_t pending_reqs[$];
  plot_t     plot_q[$];
  circ_req_t cur_req;
  plot_t     plot_exp;

  bit idle_on = 1'b1;
  int in_gap = 0;
  int stall_left = 0;
  int out_len;
  int n_fail = 0;
  int n_loads = 0;
  int n_steps = 0;
  int n_plots = 0;

  antialiased_circle_rasterizer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .radius_fixed_i (radius_fixed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .intensity_o    (intensity_o),
    .last_o         (last_o),
    .finished_o     (finished_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_len(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic plot_t mk_plot(longint px, longint py, longint inten);
    plot_t p;
    p.px      = PIX_W'(px);
    p.py      = PIX_W'(py);
    p.inten   = INT_W'(inten & AA_MASK);
    p.is_last = 1'b0;
    p.is_fin  = 1'b0;
    return p;
  endfunction

  // advance the circle model by one request and queue the plots it causes
  task automatic circle_advance(input circ_req_t r);
    longint x, y, fr, co, xi, yi;
    plot_t  pl[16];
    if (r.kind == REQ_LOAD) begin
      ctr_x       = longint'($signed(r.cx)) + off_x;
      ctr_y       = longint'($signed(r.cy)) + off_y;
      sub_px      = longint'(r.rad >> SUB_SHIFT);
      acc_err     = -sub_px;
      sub_py      = 0;
      circle_live = 1'b1;
    end else if (circle_live) begin
      x  = sub_px;
      y  = sub_py;
      fr = x & AA_MASK;
      co = AA_MASK - fr;
      xi = x >>> AA_FRAC_BITS;
      yi = y >>> AA_FRAC_BITS;
      // wide pixels, split horizontally
      pl[0]  = mk_plot(ctr_x + xi,     ctr_y + yi, co);
      pl[1]  = mk_plot(ctr_x + xi + 1, ctr_y + yi, fr);
      pl[2]  = mk_plot(ctr_x + xi,     ctr_y - yi, co);
      pl[3]  = mk_plot(ctr_x + xi + 1, ctr_y - yi, fr);
      pl[4]  = mk_plot(ctr_x - xi,     ctr_y - yi, co);
      pl[5]  = mk_plot(ctr_x - xi - 1, ctr_y - yi, fr);
      pl[6]  = mk_plot(ctr_x - xi,     ctr_y + yi, co);
      pl[7]  = mk_plot(ctr_x - xi - 1, ctr_y + yi, fr);
      // tall pixels, split vertically
      pl[8]  = mk_plot(ctr_x + yi, ctr_y + xi,     co);
      pl[9]  = mk_plot(ctr_x + yi, ctr_y + xi + 1, fr);
      pl[10] = mk_plot(ctr_x + yi, ctr_y - xi,     co);
      pl[11] = mk_plot(ctr_x + yi, ctr_y - xi - 1, fr);
      pl[12] = mk_plot(ctr_x - yi, ctr_y - xi,     co);
      pl[13] = mk_plot(ctr_x - yi, ctr_y - xi - 1, fr);
      pl[14] = mk_plot(ctr_x - yi, ctr_y + xi,     co);
      pl[15] = mk_plot(ctr_x - yi, ctr_y + xi + 1, fr);
      pl[15].is_last = 1'b1;
      // midpoint update; the x >= 0 test stops the loop on tiny radii
      acc_err = acc_err + ERR_BIAS + y * (2 * AA_ONE);
      y = y + AA_ONE;
      while (acc_err >= 0 && x >= 0) begin
        acc_err = acc_err - (2 * x + 2);
        x = x - 1;
      end
      sub_px      = x;
      sub_py      = y;
      circle_live = (y <= x);
      for (int k = 0; k < 16; k++) begin
        pl[k].is_fin = !circle_live;
        plot_q.push_back(pl[k]);
      end
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        circle_advance(cur_req);
        if (cur_req.kind == REQ_LOAD) n_loads++;
        else n_steps++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap     <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req         = pending_reqs.pop_front();
          req_type_i     <= cur_req.kind;
          center_x_i     <= cur_req.cx;
          center_y_i     <= cur_req.cy;
          radius_fixed_i <= cur_req.rad;
          in_valid_i     <= 1'b1;
          in_gap         <= pick_len(idle_on);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // plot monitor and output back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (plot_q.size() == 0) begin
          $error("unexpected plot x=%0d y=%0d", pixel_x_o, pixel_y_o);
          n_fail++;
        end else begin
          plot_exp = plot_q.pop_front();
          n_plots++;
          if (pixel_x_o !== plot_exp.px) begin
            $error("pixel_x expected %0d got %0d", plot_exp.px, pixel_x_o);
            n_fail++;
          end
          if (pixel_y_o !== plot_exp.py) begin
            $error("pixel_y expected %0d got %0d", plot_exp.py, pixel_y_o);
            n_fail++;
          end
          if (intensity_o !== plot_exp.inten) begin
            $error("intensity expected %0d got %0d", plot_exp.inten, intensity_o);
            n_fail++;
          end
          if (last_o !== plot_exp.is_last) begin
            $error("last expected %0d got %0d", plot_exp.is_last, last_o);
            n_fail++;
          end
          if (finished_o !== plot_exp.is_fin) begin
            $error("finished expected %0d got %0d", plot_exp.is_fin, finished_o);
            n_fail++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_len      = (idle_on && $urandom_range(0, 3) == 0) ? pick_len(1'b1) : 0;
        out_stall_i <= (out_len > 0);
        stall_left  <= (out_len > 0) ? out_len - 1 : 0;
      end
    end
  end

  task automatic push_load(input logic signed [COORD_BITS-1:0] cx,
                           input logic signed [COORD_BITS-1:0] cy,
                           input logic [RAD_W-1:0] rad);
    circ_req_t r;
    r.kind = REQ_LOAD;
    r.cx   = cx;
    r.cy   = cy;
    r.rad  = rad;
    pending_reqs.push_back(r);
  endtask

  // step request; the unused fields carry noise
  task automatic push_steps(input int count);
    circ_req_t r;
    for (int i = 0; i < count; i++) begin
      r.kind = REQ_STEP;
      r.cx   = COORD_BITS'($urandom);
      r.cy   = COORD_BITS'($urandom);
      r.rad  = RAD_W'($urandom);
      pending_reqs.push_back(r);
    end
  endtask

  // wait for all requests to be taken and all plots to drain
  task automatic settle();
    while (pending_reqs.size() != 0 || in_valid_i || plot_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_X_OFFSET) off_x = longint'($signed(data[CFG_W-1:0]));
    else off_y = longint'($signed(data[CFG_W-1:0]));
  endtask

  // both offsets, upper data bits filled with noise
  task automatic set_offsets(input logic signed [CFG_W-1:0] ox,
                             input logic signed [CFG_W-1:0] oy);
    cfg_write(ADDR_X_OFFSET, {(APB_DW - CFG_W)'($urandom_range(0, 1048575)), ox});
    cfg_write(ADDR_Y_OFFSET, {(APB_DW - CFG_W)'($urandom_range(0, 1048575)), oy});
  endtask

  // random circles, mostly complete sequences of small radius
  task automatic random_phase(input int count);
    int base, sel, sub;
    base = pending_reqs.size();
    while (pending_reqs.size() - base < count) begin
      sel = $urandom_range(0, 99);
      sub = $urandom_range(0, 120);
      if (sel < 70) begin
        push_load(COORD_BITS'($urandom), COORD_BITS'($urandom),
                  RAD_W'((sub << SUB_SHIFT) | $urandom_range(0, 8191)));
        push_steps(sub / 11 + $urandom_range(1, 3));
      end else if (sel < 80) begin
        push_load(COORD_BITS'($urandom), COORD_BITS'($urandom), RAD_W'($urandom));
        push_steps($urandom_range(1, 3));
      end else if (sel < 90) begin
        // cut short, the next load replaces it
        push_load(COORD_BITS'($urandom), COORD_BITS'($urandom),
                  RAD_W'((sub << SUB_SHIFT) | $urandom_range(0, 8191)));
        push_steps($urandom_range(0, 2));
      end else if (sel < 95) begin
        push_steps($urandom_range(1, 2));
      end else begin
        push_load(COORD_BITS'($urandom), COORD_BITS'($urandom), RAD_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset offsets, idle step, zero radius, corners, replacement
    push_steps(1);
    push_load(12'sd0, 12'sd0, 26'd0);
    push_steps(2);
    push_load(-12'sd2048, 12'sd2047, RAD_W'((3 << SUB_SHIFT) | 13'h1fff));
    push_steps(2);
    push_load(12'sd2047, -12'sd2048, {RAD_W{1'b1}});
    push_steps(2);
    push_load(12'sd5, -12'sd7, RAD_W'(40 << SUB_SHIFT));
    push_steps(5);
    settle();

    // directed: extreme offsets, wrap of the plotted coordinates
    set_offsets(12'sd2047, -12'sd2048);
    push_load(12'sd2047, -12'sd2048, {RAD_W{1'b1}});
    push_steps(2);
    push_load(-12'sd2048, 12'sd2047, RAD_W'(20 << SUB_SHIFT));
    push_steps(4);
    settle();
    set_offsets(-12'sd2048, 12'sd2047);
    push_load(-12'sd2048, 12'sd2047, {RAD_W{1'b1}});
    push_steps(2);
    push_load(12'sd0, 12'sd0, RAD_W'((16 << SUB_SHIFT) | $urandom_range(0, 8191)));
    push_steps(4);
    settle();

    // random phases under several offset settings
    set_offsets(12'sd0, 12'sd0);
    random_phase(65);
    settle();
    set_offsets(CFG_W'($urandom), CFG_W'($urandom));
    random_phase(65);
    settle();
    idle_on = 1'b0;
    set_offsets(CFG_W'($urandom), CFG_W'($urandom));
    random_phase(65);
    settle();
    idle_on = 1'b1;
    set_offsets(-12'sd2048, 12'sd2047);
    random_phase(65);
    settle();

    $display("summary: %0d loads, %0d steps accepted, %0d plots compared",
             n_loads, n_steps, n_plots);
    $display("summary: offsets at both extremes, full and cut-short circles");
    if (n_fail == 0 && plot_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: errors");
    $finish;
  end

endmodule

FILE: antialiased_circle_rasterizer.f
design/acr_pkg.sv
design/acr_apb_regs.sv
design/acr_ucode_rom.sv
design/acr_sequencer.sv
design/acr_datapath.sv
design/antialiased_circle_rasterizer.sv
tb/sv/tb.sv
